// ===== sv/csp_pkg.sv =====
// Shared types and constants for the cruise speed PID block.
// No dependencies; every other file refers to it by scoped names.
package csp_pkg;

   localparam int SPEED_WIDTH = 11;              // speed field width, 8..15
   localparam int ERR_W = SPEED_WIDTH + 1;       // signed speed error
   localparam int DER_W = SPEED_WIDTH + 2;       // signed error difference
   localparam int INT_W = 15;                    // integral accumulator
   localparam int INTS_W = INT_W + 2;            // signed integral before clamp
   localparam int GAIN_W = 8;
   localparam int CUR_W = 8;
   localparam int PWM_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = INT_W;

   localparam int PROD_P_W = ERR_W + GAIN_W + 1;
   localparam int PROD_I_W = INT_W + GAIN_W + 1;
   localparam int PROD_D_W = DER_W + GAIN_W + 1;
   localparam int SUM_W = ((PROD_D_W > PROD_I_W) ? PROD_D_W : PROD_I_W) + 2;

   localparam int REQ_DATA_W = ((2 * SPEED_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((PWM_W + CUR_W + 7) / 8) * 8;

   // Control output saturation and duty scaling (x * 255 / 1000, truncated).
   localparam int SAT_W = 10;
   localparam logic [SAT_W-1:0] OUTPUT_LIMIT = SAT_W'(1000);
   localparam int SCALE_SHIFT = 28;
   localparam int SCALE_K_W = 27;
   // 255 * ceil(2^28 / 1000)
   localparam logic [SCALE_K_W-1:0] SCALE_K = SCALE_K_W'(68451180);
   localparam int SCALE_P_W = SAT_W + SCALE_K_W;

   localparam logic [INT_W-1:0] INTEGRAL_PRESET = INT_W'(250);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_CEIL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_CEIL = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture tick, update loop state
      logic mul;     // form the three gain products
      logic sum;     // add and saturate
      logic scale;   // scale to duty, load result register
   } cmd_type;

endpackage

// ===== sv/csp_ctrl.sv =====
// Sequencer for the cruise speed PID block: tick handshake and result valid.
// Depends on csp_pkg.
module csp_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output csp_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_SUM   = 4'b0100,
      ST_SCALE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // wait here while the previous result is still unclaimed
            if (out_free) begin
               cmd.scale    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/csp_dp.sv =====
// Datapath for the cruise speed PID block: settings, loop state, products,
// saturation and duty scaling. Depends on csp_pkg.
module csp_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  csp_pkg::cmd_type                   cmd,
   input  logic                               cruise_active,
   input  logic [csp_pkg::SPEED_WIDTH-1:0]    wheel_speed,
   input  logic [csp_pkg::SPEED_WIDTH-1:0]    requested_speed,
   input  logic                               csr_we,
   input  logic [csp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [csp_pkg::PWM_W-1:0]          pwm_target,
   output logic [csp_pkg::CUR_W-1:0]          current_target
);

   localparam int SW = csp_pkg::SPEED_WIDTH;

   // settings
   logic [csp_pkg::GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [csp_pkg::INT_W-1:0]  int_ceil_ff;
   logic [csp_pkg::CUR_W-1:0]  cur_ceil_ff;

   // loop state
   logic                              restart_ff;
   logic [SW-1:0]                     held_ff, held_in;
   logic signed [csp_pkg::ERR_W-1:0]  prev_err_ff, err_in;
   logic [csp_pkg::INT_W-1:0]         integ_ff, integ_in, integ_base;
   logic signed [csp_pkg::DER_W-1:0]  deriv_ff, deriv_in;
   logic signed [csp_pkg::INTS_W-1:0] integ_raw;
   logic signed [csp_pkg::ERR_W-1:0]  prev_base;

   // per-tick pipeline
   logic                                idle_tick_ff;
   logic [csp_pkg::CUR_W-1:0]           cur_tick_ff;
   logic signed [csp_pkg::PROD_P_W-1:0] prod_p_ff;
   logic signed [csp_pkg::PROD_I_W-1:0] prod_i_ff;
   logic signed [csp_pkg::PROD_D_W-1:0] prod_d_ff;
   logic signed [csp_pkg::SUM_W-1:0]    sum_raw;
   logic [csp_pkg::SAT_W-1:0]           sat_ff, sat_in;
   logic [csp_pkg::SCALE_P_W-1:0]       scaled;
   logic [csp_pkg::PWM_W-1:0]           pwm_ff;
   logic [csp_pkg::CUR_W-1:0]           cur_out_ff;

   // settings port
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff       <= '0;
         ki_ff       <= csp_pkg::GAIN_W'(1);
         kd_ff       <= '0;
         int_ceil_ff <= csp_pkg::INT_W'(1000);
         cur_ceil_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            csp_pkg::CSR_GAIN_P:   kp_ff       <= csr_wdata[csp_pkg::GAIN_W-1:0];
            csp_pkg::CSR_GAIN_I:   ki_ff       <= csr_wdata[csp_pkg::GAIN_W-1:0];
            csp_pkg::CSR_GAIN_D:   kd_ff       <= csr_wdata[csp_pkg::GAIN_W-1:0];
            csp_pkg::CSR_INT_CEIL: int_ceil_ff <= csr_wdata[csp_pkg::INT_W-1:0];
            csp_pkg::CSR_CUR_CEIL: cur_ceil_ff <= csr_wdata[csp_pkg::CUR_W-1:0];
            default: ;
         endcase
      end
   end

   // error, clamped integral and derivative for the incoming tick
   always_comb begin
      if (restart_ff) begin
         held_in    = (requested_speed != '0) ? requested_speed : wheel_speed;
         integ_base = csp_pkg::INTEGRAL_PRESET;
         prev_base  = '0;
      end else begin
         held_in    = held_ff;
         integ_base = integ_ff;
         prev_base  = prev_err_ff;
      end
      err_in    = $signed({1'b0, held_in}) - $signed({1'b0, wheel_speed});
      integ_raw = $signed({2'b00, integ_base}) + csp_pkg::INTS_W'(err_in);
      if (integ_raw > $signed({2'b00, int_ceil_ff})) begin
         integ_in = int_ceil_ff;
      end else if (integ_raw < 0) begin
         integ_in = '0;
      end else begin
         integ_in = integ_raw[csp_pkg::INT_W-1:0];
      end
      deriv_in = csp_pkg::DER_W'(err_in) - csp_pkg::DER_W'(prev_base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff  <= 1'b1;
         held_ff     <= '0;
         prev_err_ff <= '0;
         integ_ff    <= csp_pkg::INTEGRAL_PRESET;
      end else if (cmd.load) begin
         if (cruise_active) begin
            restart_ff  <= 1'b0;
            held_ff     <= held_in;
            prev_err_ff <= err_in;     // also the error of this tick
            integ_ff    <= integ_in;
         end else begin
            restart_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idle_tick_ff <= !cruise_active;
         cur_tick_ff  <= cruise_active ? cur_ceil_ff : '0;
         deriv_ff     <= deriv_in;
      end
   end

   // gain products
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_p_ff <= $signed({1'b0, kp_ff}) * prev_err_ff;
         prod_i_ff <= $signed({1'b0, ki_ff}) * $signed({1'b0, integ_ff});
         prod_d_ff <= $signed({1'b0, kd_ff}) * deriv_ff;
      end
   end

   // sum and saturate to 0..1000
   always_comb begin
      sum_raw = csp_pkg::SUM_W'(prod_p_ff) + csp_pkg::SUM_W'(prod_i_ff)
              + csp_pkg::SUM_W'(prod_d_ff);
      if (idle_tick_ff || sum_raw < 0) begin
         sat_in = '0;
      end else if (sum_raw > $signed(csp_pkg::SUM_W'(csp_pkg::OUTPUT_LIMIT))) begin
         sat_in = csp_pkg::OUTPUT_LIMIT;
      end else begin
         sat_in = sum_raw[csp_pkg::SAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sat_ff <= sat_in;
      end
   end

   // duty = sat * 255 / 1000 via reciprocal multiply
   assign scaled = csp_pkg::SCALE_P_W'(sat_ff) * csp_pkg::SCALE_P_W'(csp_pkg::SCALE_K);

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         pwm_ff     <= scaled[csp_pkg::SCALE_SHIFT +: csp_pkg::PWM_W];
         cur_out_ff <= cur_tick_ff;
      end
   end

   assign pwm_target     = pwm_ff;
   assign current_target = cur_out_ff;

endmodule

// ===== sv/cruise_speed_pid_top.sv =====
// Top level of the cruise speed PID block: stream ports and settings port.
// Depends on csp_pkg, csp_ctrl and csp_dp.

// Cruise speed PID controller. One item on req_ is one control tick and
// yields exactly one item on rsp_. An item runs four steps (load and
// loop-state update at the accepting edge, gain products, sum and
// saturation, duty scaling), set by the sequencer stepping through its
// product, sum and scaling states. rsp_tvalid is registered and rises
// at the edge that loads the result. One tick is in flight at a time, so
// the block takes no new item until the last one has been scaled, and the
// scaling step waits while the result register is unclaimed; the next tick
// may enter while the last result still waits to be taken. An inactive tick arms
// a restart and answers zero duty and zero current. The first active tick
// after a restart latches the held speed (the requested speed, or the wheel
// speed if the request is zero), clears the previous error and presets the
// integral to 250. Duty is the PID sum saturated to 0..1000 and scaled to
// 0..255; current_target is the current ceiling setting on active ticks.
// Settings are to be written through csr_ while the block is idle, which the
// block does not enforce; writes to indexes past the list are dropped.
module cruise_speed_pid_top (
   input  logic                              clock,
   input  logic                              reset,
   // tick input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [csp_pkg::REQ_DATA_W-1:0]    req_tdata,  // wheel_speed, requested_speed
   input  logic [0:0]                        req_tuser,  // cruise_active
   // result output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [csp_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // pwm_target, current_target
   // settings
   input  logic                              csr_we,
   input  logic [csp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [csp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW = csp_pkg::SPEED_WIDTH;

   csp_pkg::cmd_type          cmd;
   logic [csp_pkg::PWM_W-1:0] pwm_target;
   logic [csp_pkg::CUR_W-1:0] current_target;

   csp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   csp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cruise_active   (req_tuser[0]),
      .wheel_speed     (req_tdata[SW-1:0]),
      .requested_speed (req_tdata[2*SW-1:SW]),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pwm_target      (pwm_target),
      .current_target  (current_target)
   );

   // pwm in the low byte, current above it; any padding is zero
   assign rsp_tdata = csp_pkg::RSP_DATA_W'({current_target, pwm_target});

endmodule

// ===== sv/csp_checker.sv =====
// Port-level checks for cruise_speed_pid_top, attached by the bind below.
// Depends on csp_pkg.
module csp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [0:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [csp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one tick at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("second item taken while busy");

   // with the output empty at acceptance, the result shows once the scaling step is done
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && !rsp_tvalid |-> ##4 rsp_tvalid)
      else $error("result late");

   // inactive tick answers zero duty and zero current
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      req_acc && !rsp_tvalid && !req_tuser[0] |-> ##4 (rsp_tdata == '0))
      else $error("inactive tick gave nonzero result");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind cruise_speed_pid_top csp_checker u_csp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
